// ===== sv/alfr_pkg.sv =====
// ----------------------------------------------------------------------------
// alfr_pkg
// Shared widths and constants of the additive lagged-Fibonacci generator.
// ----------------------------------------------------------------------------
package alfr_pkg;

   localparam int WORD_W  = 32;   // ring word and seed width
   localparam int RAW_W   = 31;   // width of an unreduced draw
   localparam int BOUND_W = 16;   // width of the bound and the reduced value

   // Park-Miller multiplier, walked one bit per step from the top bit down.
   localparam int                  PM_MULT_W = 15;
   localparam logic [PM_MULT_W-1:0] PM_MULT  = 15'd16807;
   localparam int                  PM_CNT_W  = $clog2(PM_MULT_W);

   // Park-Miller modulus, 2^31 - 1.
   localparam logic [RAW_W-1:0] PM_MOD = 31'h7fff_ffff;

   // The remainder unit retires this many dividend bits per cycle.
   localparam int REM_DIGIT_W = 2;
   localparam int REM_SR_W    = 32;
   localparam int REM_STEPS   = REM_SR_W / REM_DIGIT_W;
   localparam int REM_CNT_W   = $clog2(REM_STEPS);

endpackage

// ===== sv/alfr_if.sv =====
// ----------------------------------------------------------------------------
// alfr_req_if / alfr_rsp_if
// Valid/ready channels carrying requests into and results out of the
// generator.
// ----------------------------------------------------------------------------
interface alfr_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [alfr_pkg::WORD_W-1:0]  seed_value;
   logic [alfr_pkg::BOUND_W-1:0] bound;

   modport source (output valid, action, seed_value, bound, input ready);
   modport sink (input valid, action, seed_value, bound, output ready);
   modport monitor (input valid, ready, action, seed_value, bound);
endinterface

interface alfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [alfr_pkg::BOUND_W-1:0] value;
   logic [alfr_pkg::RAW_W-1:0]   raw_draw;
   logic                         bound_error;

   modport source (output valid, value, raw_draw, bound_error, input ready);
   modport sink (input valid, value, raw_draw, bound_error, output ready);
   modport monitor (input valid, ready, value, raw_draw, bound_error);
endinterface

// ===== sv/alfr_ram.sv =====
// ----------------------------------------------------------------------------
// alfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module alfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/alfr_pm.sv =====
// ----------------------------------------------------------------------------
// alfr_pm
// Bit-serial Park-Miller step: 16807 * w mod (2^31 - 1), w taken as signed.
// ----------------------------------------------------------------------------
module alfr_pm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [alfr_pkg::WORD_W-1:0] word_in,
   output logic                        done,
   output logic [alfr_pkg::WORD_W-1:0] word_out
);

   typedef enum logic [2:0] {
      PM_IDLE,
      PM_REDUCE,
      PM_DOUBLE,
      PM_ADD,
      PM_FIX
   } pm_state_type;

   localparam logic [alfr_pkg::WORD_W-1:0] MOD_WIDE = {1'b0, alfr_pkg::PM_MOD};

   pm_state_type                       state_ff, state_in;
   logic                               done_ff, done_in;
   logic                               neg_ff, neg_in;
   logic [alfr_pkg::WORD_W-1:0]        mag_ff, mag_in;
   logic [alfr_pkg::RAW_W-1:0]         acc_ff, acc_in;
   logic [alfr_pkg::PM_MULT_W-1:0]     mult_sr_ff, mult_sr_in;
   logic [alfr_pkg::PM_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [alfr_pkg::WORD_W-1:0]        twice;
   logic [alfr_pkg::WORD_W-1:0]        plus;

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      acc_in     = acc_ff;
      mult_sr_in = mult_sr_ff;
      cnt_in     = cnt_ff;
      twice      = {acc_ff, 1'b0};
      plus       = {1'b0, acc_ff} + mag_ff;
      case (state_ff)
         PM_IDLE: begin
            if (start) begin
               neg_in   = word_in[alfr_pkg::WORD_W-1];
               mag_in   = word_in[alfr_pkg::WORD_W-1] ?
                          (alfr_pkg::WORD_W'(0) - word_in) : word_in;
               state_in = PM_REDUCE;
            end
         end
         PM_REDUCE: begin
            // The magnitude can reach 2^31, one above the modulus.
            if (mag_ff >= MOD_WIDE) begin
               mag_in = mag_ff - MOD_WIDE;
            end
            acc_in     = '0;
            mult_sr_in = alfr_pkg::PM_MULT;
            cnt_in     = '0;
            state_in   = PM_DOUBLE;
         end
         PM_DOUBLE: begin
            acc_in   = (twice >= MOD_WIDE) ? alfr_pkg::RAW_W'(twice - MOD_WIDE)
                                           : twice[alfr_pkg::RAW_W-1:0];
            state_in = PM_ADD;
         end
         PM_ADD: begin
            if (mult_sr_ff[alfr_pkg::PM_MULT_W-1]) begin
               acc_in = (plus >= MOD_WIDE) ? alfr_pkg::RAW_W'(plus - MOD_WIDE)
                                           : plus[alfr_pkg::RAW_W-1:0];
            end
            mult_sr_in = {mult_sr_ff[alfr_pkg::PM_MULT_W-2:0], 1'b0};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == alfr_pkg::PM_CNT_W'(alfr_pkg::PM_MULT_W - 1)) begin
               state_in = PM_FIX;
            end else begin
               state_in = PM_DOUBLE;
            end
         end
         PM_FIX: begin
            // A negative input maps a non-zero remainder back to M - r.
            if (neg_ff && (acc_ff != '0)) begin
               acc_in = alfr_pkg::PM_MOD - acc_ff;
            end
            done_in  = 1'b1;
            state_in = PM_IDLE;
         end
         default: begin
            state_in = PM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      acc_ff     <= acc_in;
      mult_sr_ff <= mult_sr_in;
      cnt_ff     <= cnt_in;
   end

   assign done     = done_ff;
   assign word_out = {1'b0, acc_ff};

endmodule

// ===== sv/alfr_rem.sv =====
// ----------------------------------------------------------------------------
// alfr_rem
// Restoring remainder of a 31-bit draw by a 16-bit bound, two dividend bits
// shifted in per cycle.
// ----------------------------------------------------------------------------
module alfr_rem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [alfr_pkg::RAW_W-1:0]   dividend,
   input  logic [alfr_pkg::BOUND_W-1:0] divisor,
   output logic                         done,
   output logic [alfr_pkg::BOUND_W-1:0] remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [alfr_pkg::REM_SR_W-1:0] sr_ff, sr_in;
   logic [alfr_pkg::BOUND_W-1:0]  rem_ff, rem_in;
   logic [alfr_pkg::BOUND_W-1:0]  div_ff, div_in;
   logic [alfr_pkg::REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [alfr_pkg::BOUND_W-1:0]  part;
   logic [alfr_pkg::BOUND_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sr_in   = sr_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      part    = rem_ff;
      trial   = '0;
      if (busy_ff) begin
         // The partial remainder stays below the divisor, so each trial
         // fits in one bit more than the bound.
         for (int i = 0; i < alfr_pkg::REM_DIGIT_W; i++) begin
            trial = {part, sr_ff[alfr_pkg::REM_SR_W-1-i]};
            if (trial >= {1'b0, div_ff}) begin
               trial = trial - {1'b0, div_ff};
            end
            part = trial[alfr_pkg::BOUND_W-1:0];
         end
         rem_in = part;
         sr_in  = {sr_ff[alfr_pkg::REM_SR_W-alfr_pkg::REM_DIGIT_W-1:0],
                   {alfr_pkg::REM_DIGIT_W{1'b0}}};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == alfr_pkg::REM_CNT_W'(alfr_pkg::REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         sr_in   = {{(alfr_pkg::REM_SR_W - alfr_pkg::RAW_W){1'b0}}, dividend};
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sr_ff  <= sr_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/additive_lagged_fibonacci_rng_top.sv =====
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_rng_top
// Additive lagged-Fibonacci random number generator with bounded draws.
// ----------------------------------------------------------------------------
// Each request transaction either reseeds the generator (action 1) or draws
// one number below the requested bound (action 0), and every request gives
// exactly one result transaction. The generator state is a ring of
// RING_DEPTH 32-bit words held in a small RAM; a draw adds the rear word into
// the front word, returns the sum shifted right by one as raw_draw, and
// returns raw_draw modulo bound as value. A zero bound still advances the
// generator but gives value 0 with bound_error set. Items are handled one at
// a time. A draw passes through the ring RAM traffic (read front, read rear,
// write back), waits on the remainder unit, which retires two dividend bits
// per cycle, and loads the output register once it is free or being emptied.
// The next request can be taken in the cycle in which the result appears; a
// draw with a zero bound skips the remainder unit. A reseed, and the very
// first draw after reset, which seeds with 1, first fills the ring with the
// bit-serial Park-Miller unit and then runs RING_DEPTH * WARMUP_FACTOR
// discarded draws. The request side is ready whenever the sequencer is idle,
// even while an earlier result transaction still waits in the output
// register.
// ----------------------------------------------------------------------------
module additive_lagged_fibonacci_rng_top #(
   parameter int RING_DEPTH    = 31,
   parameter int INDEX_GAP     = 3,
   parameter int WARMUP_FACTOR = 10
) (
   input logic         clock,
   input logic         reset,
   alfr_req_if.sink    req_bus,
   alfr_rsp_if.source  rsp_bus
);

   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int WARM_TOTAL = RING_DEPTH * WARMUP_FACTOR;
   localparam int WARM_W     = (WARM_TOTAL < 2) ? 1 : $clog2(WARM_TOTAL + 1);

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);
   localparam logic [IDX_W-1:0]  GAP_IDX   = IDX_W'(INDEX_GAP);
   localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(WARM_TOTAL - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_PM_START,
      ST_PM_WAIT,
      ST_RD_FRONT,
      ST_RD_REAR,
      ST_UPDATE,
      ST_REM_WAIT,
      ST_RESULT
   } state_type;

   state_type                     state_ff, state_in;
   logic                          seeded_ff, seeded_in;
   logic                          action_ff, action_in;
   logic [alfr_pkg::WORD_W-1:0]   seed_ff, seed_in;
   logic [alfr_pkg::BOUND_W-1:0]  bound_ff, bound_in;
   logic [IDX_W-1:0]              front_ff, front_in;
   logic [IDX_W-1:0]              rear_ff, rear_in;
   logic [IDX_W-1:0]              fill_ff, fill_in;
   logic [WARM_W-1:0]             warm_ff, warm_in;
   logic                          warming_ff, warming_in;
   logic [alfr_pkg::WORD_W-1:0]   word_f_ff, word_f_in;
   logic [alfr_pkg::BOUND_W-1:0]  value_ff, value_in;
   logic [alfr_pkg::RAW_W-1:0]    raw_ff, raw_in;
   logic                          err_ff, err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [alfr_pkg::BOUND_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [alfr_pkg::RAW_W-1:0]    rsp_raw_ff, rsp_raw_in;
   logic                          rsp_err_ff, rsp_err_in;

   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [alfr_pkg::WORD_W-1:0]   ram_wr_data;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [alfr_pkg::WORD_W-1:0]   ram_rd_data;
   logic                          pm_start;
   logic                          pm_done;
   logic [alfr_pkg::WORD_W-1:0]   pm_word;
   logic                          rem_start;
   logic                          rem_done;
   logic [alfr_pkg::BOUND_W-1:0]  rem_value;
   logic [alfr_pkg::WORD_W-1:0]   sum;

   alfr_ram #(
      .WIDTH (alfr_pkg::WORD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   alfr_pm u_pm (
      .clock    (clock),
      .reset    (reset),
      .start    (pm_start),
      .word_in  (seed_ff),
      .done     (pm_done),
      .word_out (pm_word)
   );

   alfr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (sum[alfr_pkg::WORD_W-1:1]),
      .divisor   (bound_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // The rear word is the RAM's read data when the update state runs, and
   // the front word was captured in the read-rear state just before it.
   assign sum = word_f_ff + ram_rd_data;

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      action_in    = action_ff;
      seed_in      = seed_ff;
      bound_in     = bound_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      fill_in      = fill_ff;
      warm_in      = warm_ff;
      warming_in   = warming_ff;
      word_f_in    = word_f_ff;
      value_in     = value_ff;
      raw_in       = raw_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_err_in   = rsp_err_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = front_ff;
      ram_wr_data  = sum;
      ram_rd_addr  = front_ff;
      pm_start     = 1'b0;
      rem_start    = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               action_in = req_bus.action;
               bound_in  = req_bus.bound;
               // A draw before any seed runs a seed of 1 first.
               seed_in   = req_bus.action ? req_bus.seed_value
                                          : alfr_pkg::WORD_W'(1);
               if (req_bus.action || !seeded_ff) begin
                  state_in = ST_SEED;
               end else begin
                  warming_in = 1'b0;
                  state_in   = ST_RD_FRONT;
               end
            end
         end
         ST_SEED: begin
            // A zero seed is taken as one; the word goes into ring slot 0
            // and also feeds the first Park-Miller step.
            if (seed_ff == '0) begin
               seed_in = alfr_pkg::WORD_W'(1);
            end
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = (seed_ff == '0) ? alfr_pkg::WORD_W'(1) : seed_ff;
            fill_in     = IDX_W'(1);
            seeded_in   = 1'b1;
            state_in    = ST_PM_START;
         end
         ST_PM_START: begin
            pm_start = 1'b1;
            state_in = ST_PM_WAIT;
         end
         ST_PM_WAIT: begin
            if (pm_done) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = fill_ff;
               ram_wr_data = pm_word;
               seed_in     = pm_word;
               if (fill_ff == LAST_IDX) begin
                  front_in = GAP_IDX;
                  rear_in  = '0;
                  warm_in  = '0;
                  if (WARM_TOTAL == 0) begin
                     if (action_ff) begin
                        value_in = '0;
                        raw_in   = '0;
                        err_in   = 1'b0;
                        state_in = ST_RESULT;
                     end else begin
                        warming_in = 1'b0;
                        state_in   = ST_RD_FRONT;
                     end
                  end else begin
                     warming_in = 1'b1;
                     state_in   = ST_RD_FRONT;
                  end
               end else begin
                  fill_in  = fill_ff + 1'b1;
                  state_in = ST_PM_START;
               end
            end
         end
         ST_RD_FRONT: begin
            ram_rd_addr = front_ff;
            state_in    = ST_RD_REAR;
         end
         ST_RD_REAR: begin
            ram_rd_addr = rear_ff;
            word_f_in   = ram_rd_data;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = front_ff;
            ram_wr_data = sum;
            front_in    = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
            rear_in     = (rear_ff == LAST_IDX) ? '0 : rear_ff + 1'b1;
            if (warming_ff) begin
               warm_in = warm_ff + 1'b1;
               if (warm_ff == WARM_LAST) begin
                  warming_in = 1'b0;
                  if (action_ff) begin
                     value_in = '0;
                     raw_in   = '0;
                     err_in   = 1'b0;
                     state_in = ST_RESULT;
                  end else begin
                     state_in = ST_RD_FRONT;
                  end
               end else begin
                  state_in = ST_RD_FRONT;
               end
            end else begin
               raw_in = sum[alfr_pkg::WORD_W-1:1];
               if (bound_ff == '0) begin
                  value_in = '0;
                  err_in   = 1'b1;
                  state_in = ST_RESULT;
               end else begin
                  rem_start = 1'b1;
                  state_in  = ST_REM_WAIT;
               end
            end
         end
         ST_REM_WAIT: begin
            if (rem_done) begin
               value_in = rem_value;
               err_in   = 1'b0;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // Hand over to the output register once it is free or being
            // emptied in this cycle.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_raw_in   = raw_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         front_ff     <= GAP_IDX;
         rear_ff      <= '0;
         warming_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         warming_ff   <= warming_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      seed_ff      <= seed_in;
      bound_ff     <= bound_in;
      fill_ff      <= fill_in;
      warm_ff      <= warm_in;
      word_f_ff    <= word_f_in;
      value_ff     <= value_in;
      raw_ff       <= raw_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_raw_ff   <= rsp_raw_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.value       = rsp_value_ff;
   assign rsp_bus.raw_draw    = rsp_raw_ff;
   assign rsp_bus.bound_error = rsp_err_ff;

endmodule

// ===== sv/alfr_chk.sv =====
// ----------------------------------------------------------------------------
// alfr_chk
// Port-level checks of the generator: results follow requests one for one
// and carry values consistent with the request they answer.
// ----------------------------------------------------------------------------
module alfr_chk (
   input logic          clock,
   input logic          reset,
   alfr_req_if.sink     req_bus,
   alfr_rsp_if.source   rsp_bus
);

   logic                         push;
   logic                         pop;
   logic [1:0]                   count_ff, count_in;
   logic                         act0_ff, act0_in;
   logic                         act1_ff, act1_in;
   logic [alfr_pkg::BOUND_W-1:0] bnd0_ff, bnd0_in;
   logic [alfr_pkg::BOUND_W-1:0] bnd1_ff, bnd1_in;

   assign push = req_bus.valid && req_bus.ready;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   // Two-entry record of outstanding requests, oldest in entry 0.
   always_comb begin
      count_in = count_ff;
      act0_in  = act0_ff;
      act1_in  = act1_ff;
      bnd0_in  = bnd0_ff;
      bnd1_in  = bnd1_ff;
      if (pop && count_ff != 2'd0) begin
         act0_in  = act1_ff;
         bnd0_in  = bnd1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push && count_in != 2'd2) begin
         if (count_in == 2'd0) begin
            act0_in = req_bus.action;
            bnd0_in = req_bus.bound;
         end else begin
            act1_in = req_bus.action;
            bnd1_in = req_bus.bound;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      act0_ff <= act0_in;
      act1_ff <= act1_in;
      bnd0_ff <= bnd0_in;
      bnd1_ff <= bnd1_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid &&
      $stable({rsp_bus.value, rsp_bus.raw_draw, rsp_bus.bound_error}))
      else $error("result changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> count_ff != 2'd0)
      else $error("result without an outstanding request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2)
      else $error("request taken with two already outstanding");

   a_seed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && act0_ff |->
      rsp_bus.value == '0 && rsp_bus.raw_draw == '0 && !rsp_bus.bound_error)
      else $error("reseed result not all zero");

   a_draw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !act0_ff |->
      (rsp_bus.bound_error == (bnd0_ff == '0)) &&
      (rsp_bus.bound_error ? (rsp_bus.value == '0) : (rsp_bus.value < bnd0_ff)))
      else $error("draw value inconsistent with its bound");

endmodule

bind additive_lagged_fibonacci_rng_top alfr_chk u_alfr_chk (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the additive lagged-Fibonacci generator: a bursty
// request driver, a stalling result monitor and an in-order scoreboard fed by
// a cycle-free model of the ring, the reseed fill and the warm-up draws.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Generator geometry; the block is built with the same values.
   localparam int RING_LEN      = 31;
   localparam int RING_GAP      = 3;
   localparam int WARMUP_ROUNDS = 10;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 10;

   // The drain after the last result only has to cover a draw or two.
   localparam int DRAIN_CYCLES = 100;

   // Number of random request transactions after the directed opening.
   localparam int RANDOM_ITEMS = 1900;

   // The receiver holds off once, for this many cycles, after this many
   // request transactions have been accepted.
   localparam int HOLDOFF_AFTER  = 400;
   localparam int HOLDOFF_CYCLES = 600;

   // Time limit, in nanoseconds, after which the run is declared hung.
   localparam int RUN_LIMIT_NS = 4_000_000;

   typedef enum logic {
      ACT_DRAW   = 1'b0,
      ACT_RESEED = 1'b1
   } rng_action_type;

   typedef struct packed {
      rng_action_type                 action;
      logic [alfr_pkg::WORD_W-1:0]    seed_value;
      logic [alfr_pkg::BOUND_W-1:0]   bound;
   } rng_request_type;

   typedef struct packed {
      logic [alfr_pkg::BOUND_W-1:0]   value;
      logic [alfr_pkg::RAW_W-1:0]     raw_draw;
      logic                           bound_error;
   } rng_result_type;

   logic clock = 1'b0;
   logic reset;

   alfr_req_if req_if ();
   alfr_rsp_if rsp_if ();

   additive_lagged_fibonacci_rng_top #(
      .RING_DEPTH    (RING_LEN),
      .INDEX_GAP     (RING_GAP),
      .WARMUP_FACTOR (WARMUP_ROUNDS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Generator model. The ring, both indices and the seeded flag mirror the
   // block's state; every accepted request transaction is applied here in
   // order, and the result it should give is queued for the monitor.
   // ------------------------------------------------------------------------
   logic [alfr_pkg::WORD_W-1:0] ring_model [RING_LEN];
   int unsigned                 front_ix;
   int unsigned                 rear_ix;
   bit                          model_seeded;

   rng_request_type pending_requests [$];
   rng_result_type  expected_results [$];

   int mismatch_count = 0;
   int accepted_count;

   // One generator step: the rear word is added into the front word, both
   // indices move on and wrap at the end of the ring, and the sum without its
   // lowest bit is the raw draw.
   function automatic logic [alfr_pkg::RAW_W-1:0] model_advance();
      logic [alfr_pkg::WORD_W-1:0] sum;
      sum                  = ring_model[front_ix] + ring_model[rear_ix];
      ring_model[front_ix] = sum;
      front_ix             = (front_ix == RING_LEN - 1) ? 0 : front_ix + 1;
      rear_ix              = (rear_ix == RING_LEN - 1) ? 0 : rear_ix + 1;
      return sum[alfr_pkg::WORD_W-1:1];
   endfunction

   // Fill the ring from a seed with Park-Miller steps, each previous word
   // being read as a signed value, then run the discarded warm-up draws.
   function automatic void model_reseed(logic [alfr_pkg::WORD_W-1:0] seed);
      logic        negative;
      logic [63:0] magnitude;
      logic [63:0] remainder;
      int          i;
      model_seeded  = 1'b1;
      ring_model[0] = (seed == '0) ? alfr_pkg::WORD_W'(1) : seed;
      for (i = 1; i < RING_LEN; i++) begin
         negative  = ring_model[i-1][alfr_pkg::WORD_W-1];
         magnitude = negative ? {32'd0, alfr_pkg::WORD_W'(0) - ring_model[i-1]}
                              : {32'd0, ring_model[i-1]};
         remainder = (64'd16807 * magnitude) % 64'd2147483647;
         if (negative && remainder != 64'd0)
            remainder = 64'd2147483647 - remainder;
         ring_model[i] = remainder[alfr_pkg::WORD_W-1:0];
      end
      front_ix = RING_GAP;
      rear_ix  = 0;
      for (i = 0; i < RING_LEN * WARMUP_ROUNDS; i++)
         void'(model_advance());
   endfunction

   function automatic rng_result_type predict_result(rng_request_type rq);
      rng_result_type              res;
      logic [alfr_pkg::WORD_W-1:0] wide_raw;
      res = '0;
      if (rq.action == ACT_RESEED) begin
         model_reseed(rq.seed_value);
      end else begin
         // A draw on a generator that was never seeded seeds it with one.
         if (!model_seeded)
            model_reseed(alfr_pkg::WORD_W'(1));
         res.raw_draw = model_advance();
         if (rq.bound == '0) begin
            res.bound_error = 1'b1;
         end else begin
            wide_raw  = {1'b0, res.raw_draw};
            res.value = alfr_pkg::BOUND_W'(wide_raw % {16'd0, rq.bound});
         end
      end
      return res;
   endfunction

   function automatic void queue_request(rng_action_type act,
                                         logic [alfr_pkg::WORD_W-1:0] seed,
                                         logic [alfr_pkg::BOUND_W-1:0] bnd);
      rng_request_type rq;
      rq.action     = act;
      rq.seed_value = seed;
      rq.bound      = bnd;
      pending_requests.push_back(rq);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. Transactions come from the pending queue in bursts of
   // random length separated by random gaps; a gap of zero joins two bursts,
   // so there are stretches with no idling at all. An offered transaction is
   // held until the block takes it, and is applied to the model at that edge.
   // ------------------------------------------------------------------------
   rng_request_type offered;
   bit              offer_busy;
   int              burst_left;
   int              gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         accepted_count <= 0;
         offer_busy     = 1'b0;
         burst_left     = 0;
         gap_left       = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(predict_result(offered));
            accepted_count <= accepted_count + 1;
            offer_busy     = 1'b0;
         end
         if (!offer_busy) begin
            if (gap_left != 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               offered             = pending_requests.pop_front();
               req_if.valid        <= 1'b1;
               req_if.action       <= offered.action;
               req_if.seed_value   <= offered.seed_value;
               req_if.bound        <= offered.bound;
               offer_busy          = 1'b1;
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 16);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Long receiver hold-off. Once enough transactions have gone in, the
   // receiver refuses results for a long stretch while the driver keeps
   // offering, so the output register fills and the request side stalls.
   // ------------------------------------------------------------------------
   int holdoff_left;
   bit holdoff_done;

   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_done <= 1'b0;
      end else if (!holdoff_done && accepted_count >= HOLDOFF_AFTER) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver ready. An eight-bit pattern is played out cycle by cycle and a
   // fresh one is chosen whenever the six-bit index wraps: always ready, half
   // duty, sparse, or wholly random, which sometimes stalls until the next one.
   // ------------------------------------------------------------------------
   logic [7:0] stall_pattern;
   logic [5:0] pattern_ix;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         stall_pattern <= 8'hff;
         pattern_ix    <= '0;
      end else begin
         if (pattern_ix == 6'd63) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= 8'hff;
               1:       stall_pattern <= 8'h0f;
               2:       stall_pattern <= 8'h11;
               default: stall_pattern <= 8'($urandom);
            endcase
         end
         pattern_ix   <= pattern_ix + 6'd1;
         rsp_if.ready <= (holdoff_left == 0) && stall_pattern[pattern_ix[2:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Every accepted result transaction is checked field by
   // field against the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rng_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: value %0d raw_draw %0d bound_error %0b",
                   rsp_if.value, rsp_if.raw_draw, rsp_if.bound_error);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.value !== want.value) begin
               $error("value: expected %0d, actual %0d", want.value, rsp_if.value);
               mismatch_count++;
            end
            if (rsp_if.raw_draw !== want.raw_draw) begin
               $error("raw_draw: expected %0d, actual %0d", want.raw_draw, rsp_if.raw_draw);
               mismatch_count++;
            end
            if (rsp_if.bound_error !== want.bound_error) begin
               $error("bound_error: expected %0b, actual %0b",
                      want.bound_error, rsp_if.bound_error);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      logic [alfr_pkg::WORD_W-1:0]  seed;
      logic [alfr_pkg::BOUND_W-1:0] bnd;
      int                           n;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = ACT_DRAW;
      req_if.seed_value = '0;
      req_if.bound      = '0;
      rsp_if.ready      = 1'b0;

      for (n = 0; n < RING_LEN; n++)
         ring_model[n] = '0;
      front_ix     = RING_GAP;
      rear_ix      = 0;
      model_seeded = 1'b0;

      // Directed opening. The first draw finds the generator unseeded; then
      // zero and extreme bounds, a zero seed, seeds with the top bit set, and
      // junk in whichever field the action ignores.
      queue_request(ACT_DRAW,   32'h0000_0000, 16'hffff);
      queue_request(ACT_DRAW,   32'hffff_ffff, 16'h0000);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h0001);
      queue_request(ACT_RESEED, 32'h0000_0000, 16'hffff);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'hffff);
      queue_request(ACT_DRAW,   32'h5555_5555, 16'h0002);
      queue_request(ACT_RESEED, 32'h0000_0001, 16'h0000);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h0000);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h8000);
      queue_request(ACT_RESEED, 32'h8000_0000, 16'haaaa);
      queue_request(ACT_DRAW,   32'haaaa_aaaa, 16'hffff);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h0007);
      queue_request(ACT_RESEED, 32'hffff_ffff, 16'h5555);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h5555);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'haaaa);
      queue_request(ACT_RESEED, 32'h7fff_ffff, 16'h0001);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h0003);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'hffff);
      queue_request(ACT_RESEED, $urandom, 16'h0000);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h0000);
      queue_request(ACT_DRAW,   32'h0000_0000, 16'h00ff);

      // Random part. Reseeds are rare because each costs a ring fill and warm-up;
      // bounds are skewed towards zero, small values and powers of two so
      // that the remainder sees all its shapes.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 179) == 0) begin
            case ($urandom_range(0, 7))
               0:       seed = '0;
               1:       seed = 32'h8000_0000 | $urandom;
               default: seed = $urandom;
            endcase
            queue_request(ACT_RESEED, seed, 16'($urandom));
         end else begin
            case ($urandom_range(0, 9))
               0:          bnd = '0;
               1, 2, 3:    bnd = 16'($urandom_range(1, 16));
               4:          bnd = 16'(1) << $urandom_range(0, 15);
               default:    bnd = 16'($urandom_range(1, 65535));
            endcase
            queue_request(ACT_DRAW, $urandom, bnd);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to go in and every result to come out, then
      // let the block settle before the final verdict.
      while (pending_requests.size() != 0 || offer_busy || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("%0d expected result transactions never arrived", expected_results.size());
         mismatch_count++;
      end

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
sv/alfr_pkg.sv
sv/alfr_if.sv
sv/alfr_ram.sv
sv/alfr_pm.sv
sv/alfr_rem.sv
sv/additive_lagged_fibonacci_rng_top.sv
sv/alfr_chk.sv
verif/testbench.sv
